/* rtl/core/pli_pkg.sv */
package pli_pkg;

  // Operation codes carried on the op port.
  localparam logic [2:0] OP_INS_HEAD = 3'd0;
  localparam logic [2:0] OP_INS_TAIL = 3'd1;
  localparam logic [2:0] OP_INS_AT   = 3'd2;
  localparam logic [2:0] OP_REM_HEAD = 3'd3;
  localparam logic [2:0] OP_REM_TAIL = 3'd4;
  localparam logic [2:0] OP_REM_AT   = 3'd5;
  localparam logic [2:0] OP_DUMP     = 3'd6;
  localparam logic [2:0] OP_NONE     = 3'd7;

  // Status codes reported with each result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Kind of list walk latched by the datapath when an operation starts.
  localparam logic [1:0] KIND_INS  = 2'd0;
  localparam logic [1:0] KIND_REM  = 2'd1;
  localparam logic [1:0] KIND_DUMP = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic shift;
    logic put_handle;
    logic cnt_inc;
    logic cnt_dec;
    logic emit_err;
    logic emit_done;
    logic emit_dump;
  } pli_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic left_zero;
    logic rd_valid;
  } pli_sts_t;

endpackage

/* rtl/core/pli_ctrl.sv */
module pli_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        op,
  input  pli_pkg::pli_sts_t sts,
  output pli_pkg::pli_cmd_t cmd,
  output logic              busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_REM  = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && (op != pli_pkg::OP_NONE)) begin
          if (sts.err) begin
            cmd.emit_err = 1'b1;
          end else begin
            cmd.load = 1'b1;
            if (op inside {pli_pkg::OP_INS_HEAD, pli_pkg::OP_INS_TAIL, pli_pkg::OP_INS_AT}) begin
              state_next = S_INS;
            end else if (op inside {pli_pkg::OP_REM_HEAD, pli_pkg::OP_REM_TAIL,
                                    pli_pkg::OP_REM_AT}) begin
              state_next = S_REM;
            end else begin
              state_next = S_DUMP;
            end
          end
        end
      end
      S_INS: begin
        // Move the tail segment up one place, then drop the new handle in.
        cmd.shift = 1'b1;
        cmd.step  = !sts.left_zero;
        if (sts.left_zero && !sts.rd_valid) begin
          cmd.put_handle = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.emit_done  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_REM: begin
        // Read the victim, then pull the tail segment down one place.
        cmd.shift = 1'b1;
        cmd.step  = !sts.left_zero;
        if (sts.left_zero && !sts.rd_valid) begin
          cmd.cnt_dec   = 1'b1;
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DUMP: begin
        // One read per cycle; each read word passes through the read register into the result register.
        cmd.step      = !sts.left_zero;
        cmd.emit_dump = sts.rd_valid;
        if (sts.rd_valid && sts.left_zero) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/pli_datapath.sv */
module pli_datapath #(
  parameter int CAPACITY    = 64,
  parameter int HANDLE_BITS = 11,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [2:0]             op,
  input  logic [CW-1:0]          position,
  input  logic [HANDLE_BITS-1:0] handle,
  input  pli_pkg::pli_cmd_t      cmd,
  output pli_pkg::pli_sts_t      sts,
  output logic                   strobe,
  output logic [HANDLE_BITS-1:0] handle_out,
  output logic [1:0]             status,
  output logic                   last,
  output logic [CW-1:0]          count_out
);

  logic [HANDLE_BITS-1:0] mem [CAPACITY];
  logic [HANDLE_BITS-1:0] rdata;
  logic [HANDLE_BITS-1:0] hold_handle;
  logic [HANDLE_BITS-1:0] got;
  logic [HANDLE_BITS-1:0] mem_wd;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [CW-1:0]          epos;
  logic [CW-1:0]          hold_pos;
  logic [CW-1:0]          left;
  logic [AW-1:0]          ra;
  logic [AW-1:0]          wa;
  logic [AW-1:0]          mem_wa;
  logic [1:0]             kind;
  logic [1:0]             kind_in;
  logic [1:0]             err_code;
  logic                   err;
  logic                   rv;
  logic                   first;
  logic                   rfirst;
  logic                   mem_we;

  // Effective position, walk kind and error check for the offered item.
  always_comb begin
    epos     = '0;
    kind_in  = pli_pkg::KIND_DUMP;
    err      = 1'b0;
    err_code = pli_pkg::ST_OK;
    case (op)
      pli_pkg::OP_INS_HEAD: begin
        kind_in = pli_pkg::KIND_INS;
      end
      pli_pkg::OP_INS_TAIL: begin
        epos    = count;
        kind_in = pli_pkg::KIND_INS;
      end
      pli_pkg::OP_INS_AT: begin
        epos    = position;
        kind_in = pli_pkg::KIND_INS;
      end
      pli_pkg::OP_REM_HEAD: begin
        kind_in = pli_pkg::KIND_REM;
      end
      pli_pkg::OP_REM_TAIL: begin
        epos    = count - CW'(1);
        kind_in = pli_pkg::KIND_REM;
      end
      pli_pkg::OP_REM_AT: begin
        epos    = position;
        kind_in = pli_pkg::KIND_REM;
      end
      default: begin
        kind_in = pli_pkg::KIND_DUMP;
      end
    endcase
    if (kind_in == pli_pkg::KIND_INS) begin
      if (count == CW'(CAPACITY)) begin
        err      = 1'b1;
        err_code = pli_pkg::ST_FULL;
      end else if (epos > count) begin
        err      = 1'b1;
        err_code = pli_pkg::ST_RANGE;
      end
    end else if (kind_in == pli_pkg::KIND_REM) begin
      if (count == '0) begin
        err      = 1'b1;
        err_code = pli_pkg::ST_EMPTY;
      end else if (epos >= count) begin
        err      = 1'b1;
        err_code = pli_pkg::ST_RANGE;
      end
    end else if ((op == pli_pkg::OP_DUMP) && (count == '0)) begin
      err      = 1'b1;
      err_code = pli_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - CW'(1);
    end
  end

  assign sts.err       = err;
  assign sts.left_zero = (left == '0);
  assign sts.rd_valid  = rv;

  // Write port: a shifted word taken from the registered read data, or the new handle.
  assign mem_we = cmd.put_handle | (cmd.shift & rv & !rfirst);
  assign mem_wa = cmd.put_handle ? hold_pos[AW-1:0] : wa;
  assign mem_wd = cmd.put_handle ? hold_handle : rdata;

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.step) begin
      rdata <= mem[ra];
    end
  end

  // Control counters and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      left   <= '0;
      rv     <= 1'b0;
      first  <= 1'b0;
      rfirst <= 1'b0;
      strobe <= 1'b0;
    end else begin
      count  <= count_next;
      rv     <= cmd.step;
      rfirst <= cmd.step & first;
      strobe <= cmd.emit_err | cmd.emit_done | cmd.emit_dump;
      if (cmd.load) begin
        left  <= count - epos;
        first <= (kind_in == pli_pkg::KIND_REM);
      end else if (cmd.step) begin
        left  <= left - CW'(1);
        first <= 1'b0;
      end
    end
  end

  // Walk addresses and operands.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind        <= kind_in;
      hold_pos    <= epos;
      hold_handle <= handle;
      if (kind_in == pli_pkg::KIND_INS) begin
        ra <= AW'(count - CW'(1));
      end else begin
        ra <= epos[AW-1:0];
      end
    end else if (cmd.step) begin
      if (kind == pli_pkg::KIND_INS) begin
        ra <= ra - AW'(1);
        wa <= ra + AW'(1);
      end else begin
        ra <= ra + AW'(1);
        wa <= ra - AW'(1);
      end
    end
    if (cmd.shift && rv && rfirst) begin
      got <= rdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      handle_out <= '0;
      status     <= err_code;
      last       <= 1'b1;
      count_out  <= count;
    end else if (cmd.emit_done) begin
      handle_out <= (kind == pli_pkg::KIND_REM) ? got : '0;
      status     <= pli_pkg::ST_OK;
      last       <= 1'b1;
      count_out  <= count_next;
    end else if (cmd.emit_dump) begin
      handle_out <= rdata;
      status     <= pli_pkg::ST_OK;
      last       <= (left == '0);
      count_out  <= count;
    end
  end

endmodule

/* rtl/core/positional_list_insert_remove_core.sv */
// Channel   Transfer when          Signals
// -------   --------------------   ---------------------------------------
// command   start & !busy          op, position, handle
// result    strobe (one cycle)     handle_out, status, last, count_out
//
// Insert or remove at position p holds busy while the entries from p to the tail are
// walked; a dump holds it while every entry is read; a refused or unused operation
// never raises busy. Each result is registered and shows in the cycle after the
// cycle that made it. The entry memory does one read and one write per cycle, so a
// walk moves one entry per cycle. Reset is synchronous and empties the list; the
// entry memory is not cleared. The receiver cannot stall.
module positional_list_insert_remove_core #(
  parameter int CAPACITY    = 64,
  parameter int HANDLE_BITS = 11,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             op,
  input  logic [CW-1:0]          position,
  input  logic [HANDLE_BITS-1:0] handle,
  output logic                   strobe,
  output logic [HANDLE_BITS-1:0] handle_out,
  output logic [1:0]             status,
  output logic                   last,
  output logic [CW-1:0]          count_out
);

  pli_pkg::pli_cmd_t cmd;
  pli_pkg::pli_sts_t sts;

  // Sequencer.
  pli_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Entry memory, counters and result register.
  pli_datapath #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .position   (position),
    .handle     (handle),
    .cmd        (cmd),
    .sts        (sts),
    .strobe     (strobe),
    .handle_out (handle_out),
    .status     (status),
    .last       (last),
    .count_out  (count_out)
  );

`ifndef SYNTHESIS
  // The final result of an operation leaves the block ready for the next.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy still high with the final result");

  // A refused operation returns no handle and ends its own sequence.
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != pli_pkg::ST_OK) |-> last && (handle_out == '0))
    else $error("error result carries a handle or is not final");

  // The list never reports more entries than it can hold.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (count_out <= CW'(CAPACITY)))
    else $error("count exceeds capacity");

  // An unused opcode is dropped without a result.
  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op == pli_pkg::OP_NONE) |=> !strobe && !busy)
    else $error("unused opcode produced activity");
`endif

endmodule
